// ===== sv/u2u_pkg.sv =====
// u2u_pkg: shared types, constants and the UTF-8 encoder function for the transcoder
// no dependencies; compiled first
package u2u_pkg;

	// configuration register map
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CAP_W     = 13;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MODE     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BUFFER_CAPACITY = 1'b1;

	// register reset values
	localparam logic             MODE_UTF16   = 1'b0;
	localparam logic             MODE_LATIN1  = 1'b1;
	localparam logic [CAP_W-1:0] CAP_RESET    = 13'd64;

	// character constants
	localparam logic [5:0]  HI_SURR_TAG  = 6'h36;
	localparam logic [5:0]  LO_SURR_TAG  = 6'h37;
	localparam logic [20:0] SUPP_BASE    = 21'h010000;
	localparam logic [15:0] CTRL_LIMIT   = 16'h0020;
	localparam logic [20:0] SPACE_CHAR   = 21'h000020;
	localparam logic [20:0] LIM_1BYTE    = 21'h000080;
	localparam logic [20:0] LIM_2BYTE    = 21'h000800;
	localparam logic [20:0] LIM_3BYTE    = 21'h010000;

	// result words per item: flushed surrogate, new character, terminator
	localparam int unsigned BURST_BYTES = 7;
	localparam int unsigned BURST_W     = BURST_BYTES * 8;
	localparam int unsigned CNT_W       = 3;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        is_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_terminator;
	} out_word_t;

	// encoded character, first byte in bits 7:0
	typedef struct packed {
		logic [31:0] bytes;
		logic [2:0]  len;
	} enc_t;

	// bytes of one item handed from the decoder to the serializer
	typedef struct packed {
		logic [BURST_W-1:0] bytes;
		logic [CNT_W-1:0]   count;
		logic               term;
	} burst_t;

	// utf-8 encoding of a code point up to 0x10ffff
	function automatic enc_t utf8_enc(input logic [20:0] cp);
		enc_t e;
		e = '0;
		priority if (cp < LIM_1BYTE) begin
			e.bytes = {24'h0, 1'b0, cp[6:0]};
			e.len   = 3'd1;
		end else if (cp < LIM_2BYTE) begin
			e.bytes = {16'h0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
			e.len   = 3'd2;
		end else if (cp < LIM_3BYTE) begin
			e.bytes = {8'h0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
			e.len   = 3'd3;
		end else begin
			e.bytes = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
				5'b11110, cp[20:18]};
			e.len   = 3'd4;
		end
		return e;
	endfunction

endpackage

// ===== sv/u2u_stream_if.sv =====
// u2u_stream_if: valid/ready channel carrying one word of a given payload type
// no dependencies; payload type supplied by the instantiating level
interface u2u_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/u2u_decode.sv =====
// u2u_decode: config registers, input register, surrogate hold, byte count and
// per-item utf-8 byte assembly; depends on u2u_pkg and u2u_stream_if
module u2u_decode import u2u_pkg::*; #(
	parameter int unsigned MAX_BUFFER = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CAP_W-1:0]     cfg_data,
	u2u_stream_if.sink           unit_ch,
	output burst_t               burst,
	output logic                 burst_valid,
	input  logic                 burst_ready
);

	localparam int unsigned BW = (MAX_BUFFER > 2) ? $clog2(MAX_BUFFER) : 1;
	localparam int unsigned CW = ((BW > CAP_W) ? BW : CAP_W) + 2;

	logic             mode_q;
	logic [CAP_W-1:0] cap_q;
	logic             v_s1;
	logic [15:0]      unit_s1;
	logic             last_s1;
	logic             pend_q;
	logic [9:0]       pend_bits_q;
	logic [BW-1:0]    bw_q;

	logic             drain;
	logic             is_hi, is_lo;
	logic             has_a, has_b, pair;
	logic [20:0]      cp_a, cp_b;
	logic [15:0]      unit_b;
	enc_t             enc_a, enc_b;
	logic [CW-1:0]    cap_sat, bw_ext, bw_mid;
	logic             ok_a, ok_b;
	logic [2:0]       len_a, len_b;
	logic             pend_d;
	logic [9:0]       pend_bits_d;
	logic [BURST_W-1:0] vec_a, vec_b;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_UTF16;
			cap_q  <= CAP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SOURCE_MODE:     mode_q <= cfg_data[0];
				REG_BUFFER_CAPACITY: cap_q  <= cfg_data;
			endcase
		end
	end

	// input register
	assign drain         = v_s1 && (burst.count == '0 || burst_ready);
	assign unit_ch.ready = !v_s1 || drain;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (unit_ch.ready) begin
			v_s1 <= unit_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (unit_ch.valid && unit_ch.ready) begin
			unit_s1 <= unit_ch.data.code_unit;
			last_s1 <= unit_ch.data.is_last;
		end
	end

	// character selection: held surrogate or pair first, then the new unit
	always_comb begin
		is_hi       = unit_s1[15:10] == HI_SURR_TAG;
		is_lo       = unit_s1[15:10] == LO_SURR_TAG;
		pair        = (mode_q == MODE_UTF16) && pend_q && is_lo;
		has_a       = pend_q;
		cp_a        = pair ? (SUPP_BASE + {1'b0, pend_bits_q, unit_s1[9:0]})
			: {5'h0, HI_SURR_TAG, pend_bits_q};
		pend_d      = 1'b0;
		pend_bits_d = '0;
		unit_b      = (mode_q == MODE_LATIN1) ? {8'h0, unit_s1[7:0]} : unit_s1;
		has_b       = !pair;
		if (mode_q == MODE_UTF16 && !pair && is_hi && !last_s1) begin
			has_b       = 1'b0;
			pend_d      = 1'b1;
			pend_bits_d = unit_s1[9:0];
		end
		cp_b = (unit_b < CTRL_LIMIT) ? SPACE_CHAR : {5'h0, unit_b};
	end

	assign enc_a = utf8_enc(cp_a);
	assign enc_b = utf8_enc(cp_b);

	// buffer space check, one character after the other
	always_comb begin
		cap_sat = (CW'(cap_q) > CW'(MAX_BUFFER)) ? CW'(MAX_BUFFER) : CW'(cap_q);
		bw_ext  = CW'(bw_q);
		ok_a    = has_a && ((bw_ext + CW'(enc_a.len)) < cap_sat);
		len_a   = ok_a ? enc_a.len : 3'd0;
		bw_mid  = bw_ext + CW'(len_a);
		ok_b    = has_b && ((bw_mid + CW'(enc_b.len)) < cap_sat);
		len_b   = ok_b ? enc_b.len : 3'd0;
	end

	// pack the item's bytes; the terminator byte is zero
	always_comb begin
		vec_a       = ok_a ? BURST_W'(enc_a.bytes) : '0;
		vec_b       = ok_b ? BURST_W'(enc_b.bytes) : '0;
		burst.bytes = vec_a | (vec_b << {len_a, 3'b000});
		burst.count = len_a + len_b + CNT_W'(last_s1);
		burst.term  = last_s1;
	end

	assign burst_valid = v_s1 && burst.count != '0;

	// surrogate hold and byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			pend_bits_q <= '0;
			bw_q        <= '0;
		end else if (drain) begin
			pend_q      <= pend_d;
			pend_bits_q <= pend_bits_d;
			bw_q        <= last_s1 ? '0 : BW'(bw_mid + CW'(len_b));
		end
	end

`ifndef SYNTHESIS
	a_burst_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		burst_valid |-> burst.count != '0)
		else $error("burst offered with no bytes");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		drain && last_s1 |=> bw_q == '0 && !pend_q)
		else $error("string end did not clear count and hold");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		drain && !last_s1 |=> CW'(bw_q) < cap_sat || bw_q == '0)
		else $error("byte count reached capacity");
`endif

endmodule

// ===== sv/u2u_serial.sv =====
// u2u_serial: result register that holds one item's bytes and hands them out
// one word per cycle while byte_ch is ready; depends on u2u_pkg and u2u_stream_if
module u2u_serial import u2u_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  burst_t     burst,
	input  logic       burst_valid,
	output logic       burst_ready,
	u2u_stream_if.source byte_ch
);

	logic [BURST_W-1:0] bytes_s2;
	logic               term_s2;
	logic [CNT_W-1:0]   rem_q;
	logic               take;

	assign take        = byte_ch.valid && byte_ch.ready;
	assign burst_ready = rem_q == '0 || (rem_q == CNT_W'(1) && byte_ch.ready);

	// remaining word count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (burst_valid && burst_ready) begin
			rem_q <= burst.count;
		end else if (take) begin
			rem_q <= rem_q - CNT_W'(1);
		end
	end

	// byte shift register
	always_ff @(posedge clk) begin
		if (burst_valid && burst_ready) begin
			bytes_s2 <= burst.bytes;
			term_s2  <= burst.term;
		end else if (take) begin
			bytes_s2 <= bytes_s2 >> 8;
		end
	end

	// output word
	assign byte_ch.valid              = rem_q != '0;
	assign byte_ch.data.out_byte      = bytes_s2[7:0];
	assign byte_ch.data.is_terminator = term_s2 && rem_q == CNT_W'(1);

`ifndef SYNTHESIS
	a_term_is_nul: assert property (@(posedge clk) disable iff (!arst_n)
		byte_ch.valid && byte_ch.data.is_terminator |-> byte_ch.data.out_byte == 8'h00)
		else $error("terminator word carries a nonzero byte");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q > CNT_W'(1) |-> !burst_ready)
		else $error("new burst taken while bytes remain");
`endif

endmodule

// ===== sv/utf16be_latin1_to_utf8_transcoder.sv =====
// An accepted word enters the input register; its bytes are loaded into the
// result register once that register is free, and the first byte is offered
// from there. Throughput: each input word yields 0 to 7 bytes, handed out one
// byte per cycle while byte_ch is ready; the next word can enter the input
// register meanwhile.
// Reset (arst_n low, asynchronous): channels empty, surrogate hold and byte count
// cleared, source_mode 0, buffer_capacity 64.
module utf16be_latin1_to_utf8_transcoder import u2u_pkg::*; #(
	parameter int unsigned MAX_BUFFER = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CAP_W-1:0]     cfg_data,
	u2u_stream_if.sink           unit_ch,
	u2u_stream_if.source         byte_ch
);

	burst_t burst;
	logic   burst_valid;
	logic   burst_ready;

	// decoder and input side
	u2u_decode #(
		.MAX_BUFFER (MAX_BUFFER)
	) u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.unit_ch     (unit_ch),
		.burst       (burst),
		.burst_valid (burst_valid),
		.burst_ready (burst_ready)
	);

	// result register and byte output
	u2u_serial u_serial (
		.clk         (clk),
		.arst_n      (arst_n),
		.burst       (burst),
		.burst_valid (burst_valid),
		.burst_ready (burst_ready),
		.byte_ch     (byte_ch)
	);

endmodule
